// File: rtl/mred_pkg.sv
// shared types and constants for the modem response end detector
// no dependencies; imported by every rtl file except mred_if
package mred_pkg;

  // input operation codes
  localparam logic [1:0] OP_BYTE   = 2'd0;
  localparam logic [1:0] OP_ARM    = 2'd1;
  localparam logic [1:0] OP_CANCEL = 2'd2;
  localparam logic [1:0] OP_LOAD   = 2'd3;

  // configuration register indexes
  localparam logic [2:0] REG_FLAG_COUNT = 3'd0;
  localparam logic [2:0] REG_FLAG_LEN_A = 3'd1;

  // number of length registers, widths of the configuration port
  localparam int unsigned LEN_REGS = 5;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 6;

  // characters of interest
  localparam logic [7:0] CHAR_CR = 8'd13;
  localparam logic [7:0] CHAR_LF = 8'd10;
  localparam logic [7:0] CHAR_A  = 8'h41;
  localparam logic [7:0] CHAR_T  = 8'h54;

  // depth of the command queue between front and back
  localparam int unsigned QUEUE_DEPTH = 4;

  // default end flags, right justified, first character in the high byte
  localparam int unsigned DEF_MAX_CHARS = 11;
  localparam logic [8*DEF_MAX_CHARS-1:0] DEF_STR [LEN_REGS] = '{
    88'("OK"), 88'("ERROR"), 88'("+CMS ERROR:"), 88'("+CME ERROR:"), 88'("NO CARRIER")
  };
  localparam int unsigned DEF_LEN [LEN_REGS] = '{2, 5, 11, 11, 10};

  // command kinds handed from front to back
  typedef enum logic [2:0] {
    CMD_FEED,
    CMD_END,
    CMD_ARM,
    CMD_CANCEL,
    CMD_LOAD
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] data;
    logic       cr_first;
    logic [2:0] slot;
    logic [5:0] pos;
  } cmd_t;

  // reset contents of the flag store
  function automatic logic [7:0] default_char(input int unsigned slot, input int unsigned pos);
    logic [7:0] c;
    c = 8'h00;
    if (slot < LEN_REGS && pos < DEF_LEN[slot]) begin
      c = DEF_STR[slot][(DEF_LEN[slot] - 1 - pos) * 8 +: 8];
    end
    return c;
  endfunction

  function automatic logic [5:0] default_len(input int unsigned slot);
    return 6'(DEF_LEN[slot]);
  endfunction

endpackage

// File: rtl/mred_if.sv
// channel interfaces of the modem response end detector
// item, result and configuration channels; no dependencies
interface mred_item_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [7:0] data_byte;
  logic [2:0] flag_slot;
  logic [5:0] char_pos;
  modport source(output valid, op, data_byte, flag_slot, char_pos, input ready);
  modport sink(input valid, op, data_byte, flag_slot, char_pos, output ready);
endinterface

interface mred_result_if;
  logic       valid;
  logic       ready;
  logic       is_echo;
  logic       matched;
  logic [2:0] match_slot;
  modport source(output valid, is_echo, matched, match_slot, input ready);
  modport sink(input valid, is_echo, matched, match_slot, output ready);
endinterface

interface mred_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] index;
  logic [5:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// File: rtl/mred_front.sv
// front end: accepts item transactions, splits lines at cr lf, issues commands
// depends on mred_pkg and mred_item_if
module mred_front import mred_pkg::*; #(
  parameter int unsigned MAX_FLAGS  = 5,
  parameter int unsigned FLAG_CHARS = 63
) (
  input  logic         clk,
  input  logic         rst,
  mred_item_if.sink    rx,
  input  logic         q_full,
  output logic         push,
  output cmd_t         push_cmd
);

  logic cr_pending;
  logic cr_pending_next;
  logic accept;
  logic want_push;

  assign rx.ready = !q_full;
  assign accept   = rx.valid && rx.ready;
  assign push     = accept && want_push;

  // classify the item into a command
  always_comb begin
    push_cmd.kind     = CMD_FEED;
    push_cmd.data     = rx.data_byte;
    push_cmd.cr_first = 1'b0;
    push_cmd.slot     = rx.flag_slot;
    push_cmd.pos      = rx.char_pos;
    want_push         = 1'b0;
    cr_pending_next   = cr_pending;
    case (rx.op)
      OP_BYTE: begin
        if (cr_pending) begin
          want_push = 1'b1;
          if (rx.data_byte == CHAR_LF) begin
            push_cmd.kind   = CMD_END;
            cr_pending_next = 1'b0;
          end else if (rx.data_byte != CHAR_CR) begin
            // held cr goes into the line ahead of this byte
            push_cmd.cr_first = 1'b1;
            cr_pending_next   = 1'b0;
          end
        end else if (rx.data_byte == CHAR_CR) begin
          cr_pending_next = 1'b1;
        end else begin
          want_push = 1'b1;
        end
      end
      OP_ARM: begin
        push_cmd.kind = CMD_ARM;
        want_push     = 1'b1;
      end
      OP_CANCEL: begin
        push_cmd.kind = CMD_CANCEL;
        want_push     = 1'b1;
      end
      OP_LOAD: begin
        push_cmd.kind = CMD_LOAD;
        want_push     = ({1'b0, rx.flag_slot} < 4'(MAX_FLAGS)) &&
                        ({1'b0, rx.char_pos} < 7'(FLAG_CHARS));
      end
      default: begin
        want_push = 1'b0;
      end
    endcase
  end

  // held carriage return
  always_ff @(posedge clk) begin
    if (rst) begin
      cr_pending <= 1'b0;
    end else if (accept) begin
      cr_pending <= cr_pending_next;
    end
  end

endmodule

// File: rtl/mred_queue.sv
// short command queue decoupling the front end from the matcher
// depends on mred_pkg
module mred_queue import mred_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output cmd_t head_cmd
);

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_pop;

  assign full       = (count == CNT_W'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_cmd   = entries[rd_ptr];
  assign do_pop     = pop && head_valid;

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      if (push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (!push && do_pop) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

// File: rtl/mred_back.sv
// back end: flag store, shift-and matchers, line state and result register
// depends on mred_pkg, mred_cfg_if and mred_result_if
module mred_back import mred_pkg::*; #(
  parameter int unsigned MAX_FLAGS  = 5,
  parameter int unsigned FLAG_CHARS = 63
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  input  cmd_t          q_cmd,
  output logic          q_pop,
  mred_cfg_if.sink      cfg,
  mred_result_if.source rsp
);

  localparam int unsigned NUM_SLOTS = (MAX_FLAGS < LEN_REGS) ? MAX_FLAGS : LEN_REGS;

  typedef struct packed {
    logic [1:0] len;
    logic [7:0] first;
    logic       echo;
  } hdr_t;

  // configuration
  logic [2:0] flag_count;
  logic [5:0] flag_len [LEN_REGS];

  // flag store and line state
  logic [7:0]            pat [NUM_SLOTS][FLAG_CHARS];
  logic [FLAG_CHARS-1:0] pm [NUM_SLOTS];
  logic [NUM_SLOTS-1:0]  hit_mask;
  hdr_t                  hdr;
  logic                  awaiting;

  // result register
  logic       rsp_valid;
  logic       rsp_echo;
  logic       rsp_matched;
  logic [2:0] rsp_slot;

  // combinational matcher signals
  logic [NUM_SLOTS-1:0]  act;
  logic [5:0]            eff_len [NUM_SLOTS];
  logic [FLAG_CHARS-1:0] eq_b [NUM_SLOTS];
  logic [FLAG_CHARS-1:0] eq_cr [NUM_SLOTS];
  logic [FLAG_CHARS-1:0] last [NUM_SLOTS];
  logic [FLAG_CHARS-1:0] pm1 [NUM_SLOTS];
  logic [FLAG_CHARS-1:0] pm_next [NUM_SLOTS];
  logic [NUM_SLOTS-1:0]  byte_hits;
  logic [NUM_SLOTS-1:0]  end_mask;
  logic [2:0]            low_slot;
  logic                  line_match;
  hdr_t                  hdr1;
  hdr_t                  hdr_next;
  logic                  do_cmd;
  logic                  emit;

  function automatic hdr_t feed_hdr(input hdr_t h, input logic [7:0] b);
    hdr_t r;
    r = h;
    if (h.len == 2'd0) begin
      r.first = b;
    end else if (h.len == 2'd1) begin
      r.echo = (h.first == CHAR_A) && (b == CHAR_T);
    end
    if (h.len != 2'd2) begin
      r.len = h.len + 2'd1;
    end
    return r;
  endfunction

  assign cfg.ready      = 1'b1;
  assign rsp.valid      = rsp_valid;
  assign rsp.is_echo    = rsp_echo;
  assign rsp.matched    = rsp_matched;
  assign rsp.match_slot = rsp_slot;

  // an end of line waits for room in the result register
  assign do_cmd = q_valid && ((q_cmd.kind != CMD_END) || !rsp_valid || rsp.ready);
  assign q_pop  = do_cmd;

  // a nonempty line produces a result transaction
  assign emit = do_cmd && (q_cmd.kind == CMD_END) && (hdr.len != 2'd0);

  // per-character comparators and shift-and update, held cr first when flagged
  always_comb begin
    for (int s = 0; s < NUM_SLOTS; s++) begin
      act[s]     = flag_count > 3'(s);
      eff_len[s] = (flag_len[s] > 6'(FLAG_CHARS)) ? 6'(FLAG_CHARS) : flag_len[s];
      for (int i = 0; i < FLAG_CHARS; i++) begin
        eq_b[s][i]  = (6'(i) < eff_len[s]) && (pat[s][i] == q_cmd.data);
        eq_cr[s][i] = (6'(i) < eff_len[s]) && (pat[s][i] == CHAR_CR);
        last[s][i]  = (eff_len[s] == 6'(i + 1));
      end
      pm1[s]       = q_cmd.cr_first ? ({pm[s][FLAG_CHARS-2:0], 1'b1} & eq_cr[s]) : pm[s];
      pm_next[s]   = {pm1[s][FLAG_CHARS-2:0], 1'b1} & eq_b[s];
      byte_hits[s] = act[s] && ((q_cmd.cr_first && |(pm1[s] & last[s])) ||
                                |(pm_next[s] & last[s]));
    end
    hdr1     = q_cmd.cr_first ? feed_hdr(hdr, CHAR_CR) : hdr;
    hdr_next = feed_hdr(hdr1, q_cmd.data);
  end

  // line end: empty flags match every line, lowest slot wins
  always_comb begin
    low_slot = 3'd0;
    for (int s = 0; s < NUM_SLOTS; s++) begin
      end_mask[s] = hit_mask[s] || (act[s] && (eff_len[s] == 6'd0));
    end
    for (int s = NUM_SLOTS - 1; s >= 0; s--) begin
      if (end_mask[s]) begin
        low_slot = 3'(s);
      end
    end
    line_match = awaiting && !hdr.echo && (|end_mask);
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      flag_count <= 3'(LEN_REGS);
      for (int k = 0; k < LEN_REGS; k++) begin
        flag_len[k] <= default_len(k);
      end
    end else if (cfg.valid) begin
      if (cfg.index == REG_FLAG_COUNT) begin
        flag_count <= cfg.data[2:0];
      end
      for (int k = 0; k < LEN_REGS; k++) begin
        if (cfg.index == REG_FLAG_LEN_A + 3'(k)) begin
          flag_len[k] <= cfg.data;
        end
      end
    end
  end

  // flag store, loaded one character per command
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < NUM_SLOTS; s++) begin
        for (int i = 0; i < FLAG_CHARS; i++) begin
          pat[s][i] <= default_char(s, i);
        end
      end
    end else if (do_cmd && q_cmd.kind == CMD_LOAD) begin
      for (int s = 0; s < NUM_SLOTS; s++) begin
        for (int i = 0; i < FLAG_CHARS; i++) begin
          if (q_cmd.slot == 3'(s) && q_cmd.pos == 6'(i)) begin
            pat[s][i] <= q_cmd.data;
          end
        end
      end
    end
  end

  // line state, wait flag and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < NUM_SLOTS; s++) begin
        pm[s] <= '0;
      end
      hit_mask    <= '0;
      hdr         <= '0;
      awaiting    <= 1'b0;
      rsp_valid   <= 1'b0;
      rsp_echo    <= 1'b0;
      rsp_matched <= 1'b0;
      rsp_slot    <= 3'd0;
    end else begin
      // result valid: load on a new line result, else clear once taken
      if (emit) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
      if (do_cmd) begin
        case (q_cmd.kind)
          CMD_FEED: begin
            for (int s = 0; s < NUM_SLOTS; s++) begin
              pm[s] <= pm_next[s];
            end
            hit_mask <= hit_mask | byte_hits;
            hdr      <= hdr_next;
          end
          CMD_END: begin
            if (hdr.len != 2'd0) begin
              rsp_echo    <= hdr.echo;
              rsp_matched <= line_match;
              rsp_slot    <= line_match ? low_slot : 3'd0;
              if (line_match) begin
                awaiting <= 1'b0;
              end
            end
            for (int s = 0; s < NUM_SLOTS; s++) begin
              pm[s] <= '0;
            end
            hit_mask <= '0;
            hdr      <= '0;
          end
          CMD_ARM: begin
            awaiting <= 1'b1;
          end
          CMD_CANCEL: begin
            awaiting <= 1'b0;
          end
          default: begin
            awaiting <= awaiting;
          end
        endcase
      end
    end
  end

endmodule

// File: rtl/modem_response_end_detector.sv
// modem response end detector, top level
// a line ending lf is reported through the command queue and the result register
// throughput: one item transaction per cycle while the 4-entry command queue has
// room; matcher update is combinational; results use a one-entry output register
// reset: flags return to the five defaults, wait and line state clear
module modem_response_end_detector import mred_pkg::*; #(
  parameter int unsigned MAX_FLAGS  = 5,
  parameter int unsigned FLAG_CHARS = 63
) (
  input  logic          clk,
  input  logic          rst,
  mred_item_if.sink     rx,
  mred_cfg_if.sink      cfg,
  mred_result_if.source rsp
);

  logic push;
  cmd_t push_cmd;
  logic q_full;
  logic q_pop;
  logic q_valid;
  cmd_t q_cmd;

  // classify incoming transactions
  mred_front #(
    .MAX_FLAGS (MAX_FLAGS),
    .FLAG_CHARS(FLAG_CHARS)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .rx      (rx),
    .q_full  (q_full),
    .push    (push),
    .push_cmd(push_cmd)
  );

  // command queue
  mred_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_cmd  (push_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .head_valid(q_valid),
    .head_cmd  (q_cmd)
  );

  // matching and result generation
  mred_back #(
    .MAX_FLAGS (MAX_FLAGS),
    .FLAG_CHARS(FLAG_CHARS)
  ) u_back (
    .clk    (clk),
    .rst    (rst),
    .q_valid(q_valid),
    .q_cmd  (q_cmd),
    .q_pop  (q_pop),
    .cfg    (cfg),
    .rsp    (rsp)
  );

endmodule
